@@ sv/xsr_pkg.sv @@
// Shared constants, types and a helper function for the xoshiro256++ generator.
package xsr_pkg;

   localparam int WORD_WIDTH     = 64;
   localparam int HALF_WIDTH     = WORD_WIDTH / 2;
   localparam int FRAC_WIDTH     = 24;
   localparam int WORD_COUNT     = 4;
   localparam int INDEX_WIDTH    = $clog2(WORD_COUNT);
   localparam int RSP_DATA_WIDTH = ((WORD_WIDTH + FRAC_WIDTH + 7) / 8) * 8;

   localparam logic [WORD_WIDTH-1:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [WORD_WIDTH-1:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [WORD_WIDTH-1:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;

   localparam int MIX_SHIFT_A  = 30;
   localparam int MIX_SHIFT_B  = 27;
   localparam int MIX_SHIFT_C  = 31;
   localparam int OUT_ROT      = 23;
   localparam int SHIFT_T      = 17;
   localparam int STATE_ROT    = 45;
   localparam int FRAC_SHIFT   = WORD_WIDTH - FRAC_WIDTH;

   // Operation codes carried in the request tuser bit.
   typedef enum logic {
      OP_NEXT   = 1'b0,
      OP_RESEED = 1'b1
   } opcode_type;

   // One state-word write from the seeding sequencer.
   typedef struct packed {
      logic                   valid;
      logic [INDEX_WIDTH-1:0] index;
      logic [WORD_WIDTH-1:0]  word;
   } seed_write_type;

   // Rotate left by a constant amount between 1 and 63.
   function automatic logic [WORD_WIDTH-1:0] rotl(input logic [WORD_WIDTH-1:0] value,
                                                  input int amount);
      rotl = (value << amount) | (value >> (WORD_WIDTH - amount));
   endfunction

endpackage

@@ sv/xsr_mul_unit.sv @@
// Iterative 64x64 multiplier giving the low 64 bits, built on one 32x32 multiplier.
module xsr_mul_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [xsr_pkg::WORD_WIDTH-1:0] a_value,
   input  logic [xsr_pkg::WORD_WIDTH-1:0] b_value,
   output logic                           done,
   output logic [xsr_pkg::WORD_WIDTH-1:0] product
);

   localparam int HW = xsr_pkg::HALF_WIDTH;
   localparam int WW = xsr_pkg::WORD_WIDTH;

   localparam logic [1:0] STEP_LOW_LOW  = 2'd0;
   localparam logic [1:0] STEP_LOW_HIGH = 2'd1;
   localparam logic [1:0] STEP_HIGH_LOW = 2'd2;

   logic [WW-1:0] a_ff, a_in;
   logic [WW-1:0] b_ff, b_in;
   logic [WW-1:0] acc_ff, acc_in;
   logic [1:0]    step_ff, step_in;
   logic          active_ff, active_in;
   logic          done_ff, done_in;

   logic [HW-1:0] op_x, op_y;
   logic [WW-1:0] partial;

   always_comb begin
      case (step_ff)
         STEP_LOW_LOW: begin
            op_x = a_ff[HW-1:0];
            op_y = b_ff[HW-1:0];
         end
         STEP_LOW_HIGH: begin
            op_x = a_ff[HW-1:0];
            op_y = b_ff[WW-1:HW];
         end
         default: begin
            op_x = a_ff[WW-1:HW];
            op_y = b_ff[HW-1:0];
         end
      endcase
      partial = op_x * op_y;
   end

   always_comb begin
      a_in      = a_ff;
      b_in      = b_ff;
      acc_in    = acc_ff;
      step_in   = step_ff;
      active_in = active_ff;
      done_in   = 1'b0;
      if (active_ff) begin
         if (step_ff == STEP_LOW_LOW) begin
            acc_in = partial;
         end else begin
            acc_in = {acc_ff[WW-1:HW] + partial[HW-1:0], acc_ff[HW-1:0]};
         end
         if (step_ff == STEP_HIGH_LOW) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end else begin
            step_in = step_ff + 2'd1;
         end
      end else if (start) begin
         a_in      = a_value;
         b_in      = b_value;
         step_in   = STEP_LOW_LOW;
         active_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      if (reset) begin
         step_ff   <= STEP_LOW_LOW;
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         step_ff   <= step_in;
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

@@ sv/xsr_seeder.sv @@
// SplitMix64 seed expansion sequencer driving the shared multiplier.
module xsr_seeder (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [xsr_pkg::WORD_WIDTH-1:0] seed,
   output logic                           busy,
   output xsr_pkg::seed_write_type        write
);

   localparam int WW = xsr_pkg::WORD_WIDTH;
   localparam int IW = xsr_pkg::INDEX_WIDTH;
   localparam logic [IW-1:0] LAST_INDEX = IW'(xsr_pkg::WORD_COUNT - 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LAUNCH = 4'b0010,
      ST_MIX_A  = 4'b0100,
      ST_MIX_B  = 4'b1000
   } seed_state_type;

   seed_state_type state_ff, state_in;
   logic [WW-1:0]  z_ff, z_in;
   logic [IW-1:0]  index_ff, index_in;

   logic          mul_start;
   logic [WW-1:0] mul_a, mul_b;
   logic          mul_done;
   logic [WW-1:0] mul_product;

   xsr_mul_unit u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a_value (mul_a),
      .b_value (mul_b),
      .done    (mul_done),
      .product (mul_product)
   );

   always_comb begin
      state_in    = state_ff;
      z_in        = z_ff;
      index_in    = index_ff;
      mul_start   = 1'b0;
      mul_a       = '0;
      mul_b       = '0;
      write.valid = 1'b0;
      write.index = index_ff;
      write.word  = mul_product ^ (mul_product >> xsr_pkg::MIX_SHIFT_C);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               z_in     = seed + xsr_pkg::GOLDEN_GAMMA;
               index_in = '0;
               state_in = ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            mul_start = 1'b1;
            mul_a     = z_ff ^ (z_ff >> xsr_pkg::MIX_SHIFT_A);
            mul_b     = xsr_pkg::MIX_MUL_A;
            state_in  = ST_MIX_A;
         end
         ST_MIX_A: begin
            if (mul_done) begin
               mul_start = 1'b1;
               mul_a     = mul_product ^ (mul_product >> xsr_pkg::MIX_SHIFT_B);
               mul_b     = xsr_pkg::MIX_MUL_B;
               state_in  = ST_MIX_B;
            end
         end
         ST_MIX_B: begin
            if (mul_done) begin
               write.valid = 1'b1;
               z_in        = z_ff + xsr_pkg::GOLDEN_GAMMA;
               index_in    = index_ff + IW'(1);
               state_in    = (index_ff == LAST_INDEX) ? ST_IDLE : ST_LAUNCH;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Reset starts an expansion of seed zero, whose first counter value is the gamma itself.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LAUNCH;
         z_ff     <= xsr_pkg::GOLDEN_GAMMA;
         index_ff <= '0;
      end else begin
         state_ff <= state_in;
         z_ff     <= z_in;
         index_ff <= index_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

@@ sv/xoshiro256pp_generator.sv @@
// Top level of the xoshiro256++ generator with SplitMix64 seeding.
//
// Requests arrive on the req_ channel: req_tuser selects the operation (0 = next word,
// 1 = reseed) and req_tdata carries the 64-bit seed, which only a reseed uses.
// A next item is taken when no seeding runs and the result register is free or being
// drained; its result appears on rsp_ in the next cycle: the 64-bit xoshiro256++ word
// from the state before the update, and above it its top 24 bits as a 0.24 fraction.
// Back-to-back next items stream at one item per cycle while rsp_tready stays high.
// A reseed item gives no result. It runs the SplitMix64 expansion on one shared
// 32x32 multiplier under a small sequencer: each of the four state words needs two
// 64-bit products of three partial products each, so the block is not ready until
// all four words are written after a reseed is accepted.
// After reset the same sequencer expands seed zero into the state, so req_tready stays
// low until all four words are written, before the first item can be taken.
// When the receiver holds rsp_tready low, the finished item waits in the result
// register and no further next item is accepted until it is taken.
module xoshiro256pp_generator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [xsr_pkg::WORD_WIDTH-1:0]        req_tdata,  // [63:0] seed_value
   input  logic                                  req_tuser,  // [0] opcode
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [xsr_pkg::RSP_DATA_WIDTH-1:0]    rsp_tdata   // [63:0] random_word,
                                                             // [87:64] unit_fraction
);

   localparam int WW = xsr_pkg::WORD_WIDTH;
   localparam int FW = xsr_pkg::FRAC_WIDTH;
   localparam int RW = xsr_pkg::RSP_DATA_WIDTH;

   logic [WW-1:0] gen_words_ff [xsr_pkg::WORD_COUNT];
   logic [WW-1:0] gen_words_in [xsr_pkg::WORD_COUNT];

   logic          rsp_valid_ff, rsp_valid_in;
   logic [RW-1:0] rsp_data_ff, rsp_data_in;

   logic                    seed_busy;
   logic                    seed_start;
   xsr_pkg::seed_write_type seed_write;

   logic          req_accept;
   logic          next_accept;
   logic [WW-1:0] s0, s1, s2, s3;
   logic [WW-1:0] random_word;
   logic [FW-1:0] unit_fraction;

   xsr_seeder u_seeder (
      .clock (clock),
      .reset (reset),
      .start (seed_start),
      .seed  (req_tdata),
      .busy  (seed_busy),
      .write (seed_write)
   );

   // The result register parts the two sides: a new item may enter while the old one leaves.
   assign req_tready  = !seed_busy && (!rsp_valid_ff || rsp_tready);
   assign req_accept  = req_tvalid && req_tready;
   assign seed_start  = req_accept && (xsr_pkg::opcode_type'(req_tuser) == xsr_pkg::OP_RESEED);
   assign next_accept = req_accept && (xsr_pkg::opcode_type'(req_tuser) == xsr_pkg::OP_NEXT);

   assign s0 = gen_words_ff[0];
   assign s1 = gen_words_ff[1];
   assign s2 = gen_words_ff[2];
   assign s3 = gen_words_ff[3];

   assign random_word   = xsr_pkg::rotl(s0 + s3, xsr_pkg::OUT_ROT) + s0;
   assign unit_fraction = random_word[xsr_pkg::FRAC_SHIFT +: FW];

   always_comb begin
      gen_words_in = gen_words_ff;
      if (seed_write.valid) begin
         gen_words_in[seed_write.index] = seed_write.word;
      end else if (next_accept) begin
         // One xoshiro256 step, with the sequential xors of the update folded together.
         gen_words_in[0] = s0 ^ s3 ^ s1;
         gen_words_in[1] = s1 ^ s2 ^ s0;
         gen_words_in[2] = s2 ^ s0 ^ (s1 << xsr_pkg::SHIFT_T);
         gen_words_in[3] = xsr_pkg::rotl(s3 ^ s1, xsr_pkg::STATE_ROT);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (next_accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RW'({unit_fraction, random_word});
      end
   end

   always_ff @(posedge clock) begin
      gen_words_ff <= gen_words_in;
      rsp_data_ff  <= rsp_data_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
